// ===== src/rpn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN evaluator package
// Shared widths, token and status codes, and the divider status bundle.
// ----------------------------------------------------------------------------
package rpn_pkg;

	localparam int unsigned DATA_W          = 32;
	localparam int unsigned CMD_W           = 3;
	localparam int unsigned STATUS_W        = 2;
	localparam int unsigned STACK_DEPTH_DEF = 16;

	// Token kinds.
	localparam logic [CMD_W-1:0] CMD_OPERAND = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD     = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SUB     = 3'd2;
	localparam logic [CMD_W-1:0] CMD_MUL     = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DIV     = 3'd4;

	// Status codes.
	localparam logic [STATUS_W-1:0] ERR_NONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ERR_UNDERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] ERR_OVERFLOW  = 2'd2;
	localparam logic [STATUS_W-1:0] ERR_DIVZERO   = 2'd3;

	typedef struct packed {
		logic busy;
		logic done;
	} div_sts_t;

endpackage

// ===== src/rpn_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN evaluator channels
// Token channel into the evaluator and result channel out of it.
// ----------------------------------------------------------------------------
interface rpn_in_if;
	logic                                valid;
	logic                                ready;
	logic [rpn_pkg::CMD_W-1:0]           command;
	logic signed [rpn_pkg::DATA_W-1:0]   operand_value;
	logic                                last_token;

	modport source (output valid, output command, output operand_value, output last_token,
		input ready);
	modport sink (input valid, input command, input operand_value, input last_token,
		output ready);
endinterface

interface rpn_out_if;
	logic                                valid;
	logic                                ready;
	logic signed [rpn_pkg::DATA_W-1:0]   result_value;
	logic [rpn_pkg::STATUS_W-1:0]        status;

	modport source (output valid, output result_value, output status, input ready);
	modport sink (input valid, input result_value, input status, output ready);
endinterface

// ===== src/rpn_stack_evaluator.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN stack evaluator
// Postfix expression evaluator with an operand stack held in a RAM.
// ----------------------------------------------------------------------------
//
//   Channel   Role   Beat contents
//   tokens    sink   command, operand_value, last_token
//   results   source result_value, status (one beat per last token)
//
// An operand token is handled as it is taken. An add, subtract or multiply
// then waits in a fetch state on the registered read of the stack RAM, and a
// divide also waits on the bit-serial divider. A last token then forms the
// result in a finish state, waiting there while the result register is still
// full. Reset clears the stack count, the error flag and the result register;
// the stack RAM needs no clearing because only entries below the count are read.
//
module rpn_stack_evaluator #(
	parameter int unsigned STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	rpn_in_if.sink         tokens,
	rpn_out_if.source      results
);

	localparam int unsigned W     = rpn_pkg::DATA_W;
	localparam int unsigned CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int unsigned AW    = $clog2(STACK_DEPTH);
	localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(STACK_DEPTH);

	typedef enum logic [1:0] {S_IDLE, S_RD, S_DIV, S_FIN} state_t;

	// The top of the stack lives in top_q; the entries beneath it live in the
	// RAM at their own stack index. An operator then needs a single RAM read
	// (the left operand) while the right operand is already in hand.
	state_t                         state_q;
	logic [CNT_W-1:0]               count_q;
	logic [W-1:0]                   top_q;
	logic [rpn_pkg::STATUS_W-1:0]   err_q;
	logic [rpn_pkg::CMD_W-1:0]      cmd_q;
	logic                           last_q;
	logic                           out_valid_q;
	logic [W-1:0]                   out_value_q;
	logic [rpn_pkg::STATUS_W-1:0]   out_status_q;

	logic             accept;
	logic             is_push;
	logic             is_op;
	logic             can_push;
	logic             can_pop;
	logic             out_free;
	logic             fin_fire;
	logic [CNT_W-1:0] cnt_m1;
	logic [CNT_W-1:0] cnt_m2;

	logic             ram_we;
	logic             ram_re;
	logic [W-1:0]     left;
	logic [W-1:0]     sum;
	logic [W-1:0]     diff;
	logic [W-1:0]     prod;

	logic             div_start;
	logic [W-1:0]     div_quo;
	rpn_pkg::div_sts_t div_sts;

	// The block works on one token at a time. Because a push writes the RAM at
	// its own accept edge and an operator reads only at a later accept edge,
	// a read never overlaps a pending write to the same entry.
	assign tokens.ready = (state_q == S_IDLE);
	assign accept       = tokens.valid && tokens.ready;

	assign is_push  = (tokens.command == rpn_pkg::CMD_OPERAND);
	assign is_op    = (tokens.command >= rpn_pkg::CMD_ADD) &&
		(tokens.command <= rpn_pkg::CMD_DIV);
	assign can_push = (count_q < DEPTH_C);
	assign can_pop  = (count_q >= CNT_W'(2));
	assign cnt_m1   = count_q - CNT_W'(1);
	assign cnt_m2   = count_q - CNT_W'(2);

	// A push spills the old top into the RAM, unless the stack was empty.
	assign ram_we = accept && is_push && can_push && (count_q != '0);
	// An operator fetches the entry just below the top.
	assign ram_re = accept && is_op && can_pop;

	rpn_ram #(
		.WIDTH(W),
		.DEPTH(STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (cnt_m1[AW-1:0]),
		.wdata (top_q),
		.re    (ram_re),
		.raddr (cnt_m2[AW-1:0]),
		.rdata (left)
	);

	// Wrapping arithmetic: left operand from RAM, right operand from top_q.
	assign sum  = left + top_q;
	assign diff = left - top_q;
	assign prod = left * top_q;

	assign div_start = (state_q == S_RD) && (cmd_q == rpn_pkg::CMD_DIV) && (top_q != '0);

	rpn_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (left),
		.divisor  (top_q),
		.quotient (div_quo),
		.sts      (div_sts)
	);

	// The result register frees up in the same cycle its beat is taken.
	assign out_free = !out_valid_q || results.ready;
	// A new result beat is loaded in this cycle.
	assign fin_fire = (state_q == S_FIN) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			top_q        <= '0;
			err_q        <= rpn_pkg::ERR_NONE;
			cmd_q        <= rpn_pkg::CMD_OPERAND;
			last_q       <= 1'b0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_status_q <= rpn_pkg::ERR_NONE;
		end else begin
			// Loading a new beat wins over draining the old one.
			if (fin_fire) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						cmd_q  <= tokens.command;
						last_q <= tokens.last_token;
						if (is_push) begin
							if (can_push) begin
								top_q   <= tokens.operand_value;
								count_q <= count_q + CNT_W'(1);
							end else if (err_q == rpn_pkg::ERR_NONE) begin
								err_q <= rpn_pkg::ERR_OVERFLOW;
							end
							if (tokens.last_token) begin
								state_q <= S_FIN;
							end
						end else if (is_op && can_pop) begin
							state_q <= S_RD;
						end else begin
							// Too few operands: flag it and leave the stack alone.
							// Unused command codes fall through here untouched.
							if (is_op && err_q == rpn_pkg::ERR_NONE) begin
								err_q <= rpn_pkg::ERR_UNDERFLOW;
							end
							if (tokens.last_token) begin
								state_q <= S_FIN;
							end
						end
					end
				end
				S_RD: begin
					// Left operand is now on the RAM read port.
					case (cmd_q)
						rpn_pkg::CMD_ADD: begin
							top_q   <= sum;
							count_q <= cnt_m1;
							state_q <= last_q ? S_FIN : S_IDLE;
						end
						rpn_pkg::CMD_SUB: begin
							top_q   <= diff;
							count_q <= cnt_m1;
							state_q <= last_q ? S_FIN : S_IDLE;
						end
						rpn_pkg::CMD_MUL: begin
							top_q   <= prod;
							count_q <= cnt_m1;
							state_q <= last_q ? S_FIN : S_IDLE;
						end
						default: begin
							if (top_q == '0) begin
								// Divide by zero pops both operands and pushes zero.
								if (err_q == rpn_pkg::ERR_NONE) begin
									err_q <= rpn_pkg::ERR_DIVZERO;
								end
								top_q   <= '0;
								count_q <= cnt_m1;
								state_q <= last_q ? S_FIN : S_IDLE;
							end else begin
								state_q <= S_DIV;
							end
						end
					endcase
				end
				S_DIV: begin
					if (div_sts.done) begin
						top_q   <= div_quo;
						count_q <= cnt_m1;
						state_q <= last_q ? S_FIN : S_IDLE;
					end
				end
				S_FIN: begin
					if (out_free) begin
						// An empty stack gives zero and counts as underflow
						// unless an earlier error is already held.
						out_value_q  <= (count_q != '0) ? top_q : '0;
						out_status_q <= ((count_q == '0) && (err_q == rpn_pkg::ERR_NONE)) ?
							rpn_pkg::ERR_UNDERFLOW : err_q;
						count_q      <= '0;
						err_q        <= rpn_pkg::ERR_NONE;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign results.valid        = out_valid_q;
	assign results.result_value = out_value_q;
	assign results.status       = out_status_q;

	// The stack count never passes the configured depth.
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= DEPTH_C)
	else $error("stack count beyond depth");

	// The operand-fetch state always follows a RAM read issued in the cycle before.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RD) |-> $past(ram_re))
	else $error("operand fetch without a RAM read");

	// The divider only runs or reports completion while the sequencer waits for it.
	assert property (@(posedge clk) disable iff (!arst_n)
		(div_sts.busy || div_sts.done) |-> (state_q == S_DIV))
	else $error("divider active outside divide wait");

	// Emitting a result clears the expression state and fills the result register.
	assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == S_FIN) && out_free) |=>
		((count_q == '0) && (err_q == rpn_pkg::ERR_NONE) && out_valid_q))
	else $error("expression state not cleared after result");

endmodule

// ===== src/rpn_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN generic RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module rpn_ram #(
	parameter int unsigned WIDTH = rpn_pkg::DATA_W,
	parameter int unsigned DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/rpn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RPN divider
// Signed 32-bit division truncating toward zero, radix 2, one bit a cycle.
// ----------------------------------------------------------------------------
module rpn_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [rpn_pkg::DATA_W-1:0]    dividend,
	input  logic [rpn_pkg::DATA_W-1:0]    divisor,
	output logic [rpn_pkg::DATA_W-1:0]    quotient,
	output rpn_pkg::div_sts_t             sts
);

	localparam int unsigned W      = rpn_pkg::DATA_W;
	localparam int unsigned STEP_W = $clog2(W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(W - 1);

	typedef enum logic [1:0] {D_IDLE, D_RUN, D_FIX} dstate_t;

	dstate_t           state_q;
	logic [STEP_W-1:0] step_q;
	logic [W-1:0]      rem_q;
	logic [W-1:0]      quo_q;
	logic [W-1:0]      dvs_q;
	logic              neg_q;
	logic              done_q;
	logic [W:0]        trial;

	// Trial subtraction of the divisor from the partial remainder.
	assign trial = {rem_q, quo_q[W-1]} - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			done_q  <= 1'b0;
			step_q  <= '0;
			rem_q   <= '0;
			quo_q   <= '0;
			dvs_q   <= '0;
			neg_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (start) begin
						quo_q   <= dividend[W-1] ? (W'(0) - dividend) : dividend;
						dvs_q   <= divisor[W-1] ? (W'(0) - divisor) : divisor;
						rem_q   <= '0;
						neg_q   <= dividend[W-1] ^ divisor[W-1];
						step_q  <= '0;
						state_q <= D_RUN;
					end
				end
				D_RUN: begin
					if (!trial[W]) begin
						rem_q <= trial[W-1:0];
						quo_q <= {quo_q[W-2:0], 1'b1};
					end else begin
						rem_q <= {rem_q[W-2:0], quo_q[W-1]};
						quo_q <= {quo_q[W-2:0], 1'b0};
					end
					step_q <= step_q + STEP_W'(1);
					if (step_q == LAST_STEP) begin
						state_q <= D_FIX;
					end
				end
				D_FIX: begin
					if (neg_q) begin
						quo_q <= W'(0) - quo_q;
					end
					done_q  <= 1'b1;
					state_q <= D_IDLE;
				end
				default: begin
					state_q <= D_IDLE;
				end
			endcase
		end
	end

	assign quotient = quo_q;
	assign sts.busy = (state_q != D_IDLE);
	assign sts.done = done_q;

endmodule
